@@ rtl/nfw_potential_force_assert.svh @@
// Assertion macros for the checker file.
`ifndef NFW_POTENTIAL_FORCE_ASSERT_SVH
`define NFW_POTENTIAL_FORCE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define NFWPF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NFWPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/nfwpf_pkg.sv @@
// ----------------------------------------------------------------------------
// nfwpf_pkg
// Shared constants and types for the NFW halo potential/force pipeline.
// ----------------------------------------------------------------------------
package nfwpf_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_INDEX_W    = 2;
    localparam int MANT_W         = 63;

    // ln(2) in Q0.64
    localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCALE_RADIUS     = 2'd0,
        REG_INV_SCALE_RADIUS = 2'd1,
        REG_AMPLITUDE        = 2'd2
    } cfg_reg_t;

endpackage

@@ rtl/nfwpf_div.sv @@
// ----------------------------------------------------------------------------
// nfwpf_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside. ovf flags a quotient that does not fit in QW bits.
// ----------------------------------------------------------------------------
module nfwpf_div #(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int QW = 8,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic          ovf,
    output logic [SW-1:0] side_out
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [CW-1:0] rem_reg  [0:QW];
    logic [QW-1:0] quo_reg  [0:QW];
    logic [DW-1:0] den_reg  [0:QW];
    logic          ovf_reg  [0:QW];
    logic [SW-1:0] side_reg [0:QW];
    logic          vld_reg  [0:QW];

    logic ovf_next;

    // quotient >= 2^QW exactly when num >> QW >= den
    assign ovf_next = (CW'(num) >> QW) >= CW'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= CW'(num);
            quo_reg[0]  <= '0;
            den_reg[0]  <= den;
            ovf_reg[0]  <= ovf_next;
            side_reg[0] <= side;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        localparam int B = QW - 1 - k;
        logic [CW-1:0] trial;
        logic          take;
        logic [CW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        assign trial    = CW'(den_reg[k]) << B;
        assign take     = rem_reg[k] >= trial;
        assign rem_next = take ? (rem_reg[k] - trial) : rem_reg[k];
        assign quo_next = take ? (quo_reg[k] | (QW'(1) << B)) : quo_reg[k];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                quo_reg[k+1]  <= quo_next;
                den_reg[k+1]  <= den_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign quo       = quo_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

@@ rtl/nfw_potential_force.sv @@
// ----------------------------------------------------------------------------
// nfw_potential_force
// NFW halo potential and radial force factor from a squared radius,
// fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   signals                                         dir
//  radius    radius_valid/radius_ready, radius_squared       in
//  result    result_valid/result_ready, potential,           out
//            radial_force_factor, saturated
//  cfg       cfg_valid/cfg_ready, cfg_index, cfg_data        in
//
//  One item per cycle while the output register is not stalled; the pipeline is built from
//  the bit-per-stage square root, the 2*F log squaring stages and the five
//  bit-per-stage dividers (RW, QU1, QU2 as declared below).
//  Reset clears all valid bits and loads a = 1.0, 1/a = 1.0, F = 4.625.
//  A result held in the output register and not taken freezes every stage;
//  no transfer is lost or repeated.
module nfw_potential_force
    import nfwpf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         radius_valid,
    output logic                         radius_ready,
    input  logic [DATA_WIDTH-1:0]        radius_squared,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic signed [DATA_WIDTH-1:0] potential,
    output logic signed [DATA_WIDTH-1:0] radial_force_factor,
    output logic                         saturated,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [DATA_WIDTH-1:0]        cfg_data
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int SNW = W + F;
    localparam int RW  = (SNW + 1) / 2;
    localparam int TW  = 2 * RW + 1;
    localparam int XW  = RW + W - F;
    localparam int YW  = XW + 1;
    localparam int EW  = $clog2(YW);
    localparam int LW  = EW + F;
    localparam int AW  = ((RW > W) ? RW : W) + 1;
    localparam int QU2 = W + RW - F;
    localparam int QU1 = W + 2 * RW - 2 * F;

    localparam logic [W-1:0]  A_RST   = W'(1) << F;
    localparam logic [W-1:0]  AMP_RST = W'((64'd37 << F) >> 3);
    localparam logic [W-1:0]  CAP     = W'(1) << (W - 1);
    localparam logic [31:0]   LN2_HI  = LN2_Q64[63:32];
    localparam logic [31:0]   LN2_LO  = LN2_Q64[31:0];

    // ---------------- configuration ----------------
    logic [W-1:0] scale_radius_reg;
    logic [W-1:0] inv_radius_reg;
    logic [W-1:0] amplitude_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_radius_reg <= A_RST;
            inv_radius_reg   <= A_RST;
            amplitude_reg    <= AMP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SCALE_RADIUS:     scale_radius_reg <= cfg_data;
                REG_INV_SCALE_RADIUS: inv_radius_reg   <= cfg_data;
                REG_AMPLITUDE:        amplitude_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- global advance ----------------
    logic result_valid_reg;
    logic adv;

    assign adv          = !result_valid_reg || result_ready;
    assign radius_ready = adv;

    // ---------------- square root ----------------
    logic [TW-1:0] sq_rem_reg [0:RW];
    logic [RW-1:0] sq_res_reg [0:RW];
    logic          sq_z_reg   [0:RW];
    logic          sq_vld_reg [0:RW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_vld_reg[0] <= radius_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rem_reg[0] <= TW'({radius_squared, {F{1'b0}}});
            sq_res_reg[0] <= '0;
            sq_z_reg[0]   <= (radius_squared == '0);
        end
    end

    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        localparam int B = RW - 1 - k;
        logic [TW-1:0] trial;
        logic          take;
        logic [TW-1:0] rem_next;
        logic [RW-1:0] res_next;

        // (res + 2^B)^2 - res^2 with res having no bits below B+1
        assign trial    = (TW'(sq_res_reg[k]) << (B + 1)) | (TW'(1) << (2 * B));
        assign take     = sq_rem_reg[k] >= trial;
        assign rem_next = take ? (sq_rem_reg[k] - trial) : sq_rem_reg[k];
        assign res_next = take ? (sq_res_reg[k] | (RW'(1) << B)) : sq_res_reg[k];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[k+1] <= rem_next;
                sq_res_reg[k+1] <= res_next;
                sq_z_reg[k+1]   <= sq_z_reg[k];
            end
        end
    end

    // ---------------- x = r/a, y = 1 + x, leading one, normalize ----------------
    logic [RW+W-1:0] x_prod;
    logic [XW-1:0]   x_reg;
    logic [RW-1:0]   m1_r_reg;
    logic            m1_z_reg;
    logic            m1_vld_reg;

    assign x_prod = (RW + W)'(sq_res_reg[RW]) * (RW + W)'(inv_radius_reg);

    logic [YW-1:0] y_next;
    logic [EW-1:0] msb_next;
    logic [YW-1:0] y_reg;
    logic [EW-1:0] msb_reg;
    logic [RW-1:0] m2_r_reg;
    logic          m2_z_reg;
    logic          m2_vld_reg;

    assign y_next = YW'(x_reg) + (YW'(1) << F);

    always_comb
    begin
        msb_next = '0;
        for (int j = 0; j < YW; j++)
        begin
            if (y_next[j])
            begin
                msb_next = EW'(j);
            end
        end
    end

    logic [EW-1:0]     nrm_shift;
    logic [YW-1:0]     y_norm;
    logic [MANT_W-1:0] mant_next;
    logic [EW-1:0]     exp_next;

    assign nrm_shift = EW'(YW - 1) - msb_reg;
    assign y_norm    = y_reg << nrm_shift;
    assign exp_next  = msb_reg - EW'(F);

    if (YW >= MANT_W)
    begin : g_mant_trunc
        assign mant_next = y_norm[YW-1 -: MANT_W];
    end
    else
    begin : g_mant_pad
        assign mant_next = {y_norm, {(MANT_W - YW){1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_vld_reg <= sq_vld_reg[RW];
            m2_vld_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg    <= x_prod[RW+W-1:F];
            m1_r_reg <= sq_res_reg[RW];
            m1_z_reg <= sq_z_reg[RW];
            y_reg    <= y_next;
            msb_reg  <= msb_next;
            m2_r_reg <= m1_r_reg;
            m2_z_reg <= m1_z_reg;
        end
    end

    // ---------------- log2 fraction by repeated squaring ----------------
    // even stages hold the mantissa, odd stages the partial products
    logic [MANT_W-1:0] lg_mant_reg [0:F];
    logic [61:0]       lg_hh_reg   [0:F-1];
    logic [62:0]       lg_hl_reg   [0:F-1];
    logic [63:0]       lg_ll_reg   [0:F-1];
    logic [F-1:0]      lg_frac_reg [0:2*F];
    logic [EW-1:0]     lg_e_reg    [0:2*F];
    logic [RW-1:0]     lg_r_reg    [0:2*F];
    logic              lg_z_reg    [0:2*F];
    logic              lg_vld_reg  [0:2*F];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lg_vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            lg_vld_reg[0] <= m2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lg_mant_reg[0] <= mant_next;
            lg_frac_reg[0] <= '0;
            lg_e_reg[0]    <= exp_next;
            lg_r_reg[0]    <= m2_r_reg;
            lg_z_reg[0]    <= m2_z_reg;
        end
    end

    for (genvar i = 0; i < F; i++)
    begin : g_log
        logic [30:0]  mh;
        logic [31:0]  ml;
        logic [61:0]  hh_next;
        logic [62:0]  hl_next;
        logic [63:0]  ll_next;
        logic [125:0] sq_sum;
        logic [63:0]  sq_val;
        logic [MANT_W-1:0] mant_sq_next;
        logic [F-1:0] frac_next;

        assign mh      = lg_mant_reg[i][62:32];
        assign ml      = lg_mant_reg[i][31:0];
        assign hh_next = 62'(mh) * 62'(mh);
        assign hl_next = 63'(mh) * 63'(ml);
        assign ll_next = 64'(ml) * 64'(ml);

        assign sq_sum = (126'(lg_hh_reg[i]) << 64) + (126'(lg_hl_reg[i]) << 33)
                      + 126'(lg_ll_reg[i]);
        assign sq_val = sq_sum[125:62];
        assign mant_sq_next = sq_val[63] ? sq_val[63:1] : sq_val[62:0];
        assign frac_next    = {lg_frac_reg[2*i+1][F-2:0], sq_val[63]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                lg_vld_reg[2*i+1] <= 1'b0;
                lg_vld_reg[2*i+2] <= 1'b0;
            end
            else if (adv)
            begin
                lg_vld_reg[2*i+1] <= lg_vld_reg[2*i];
                lg_vld_reg[2*i+2] <= lg_vld_reg[2*i+1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                lg_hh_reg[i]        <= hh_next;
                lg_hl_reg[i]        <= hl_next;
                lg_ll_reg[i]        <= ll_next;
                lg_frac_reg[2*i+1]  <= lg_frac_reg[2*i];
                lg_e_reg[2*i+1]     <= lg_e_reg[2*i];
                lg_r_reg[2*i+1]     <= lg_r_reg[2*i];
                lg_z_reg[2*i+1]     <= lg_z_reg[2*i];
                lg_mant_reg[i+1]    <= mant_sq_next;
                lg_frac_reg[2*i+2]  <= frac_next;
                lg_e_reg[2*i+2]     <= lg_e_reg[2*i+1];
                lg_r_reg[2*i+2]     <= lg_r_reg[2*i+1];
                lg_z_reg[2*i+2]     <= lg_z_reg[2*i+1];
            end
        end
    end

    // ---------------- L = log2(y) * ln2 ----------------
    logic [LW-1:0]    log2v;
    logic [LW+31:0]   ln_ph_reg;
    logic [LW+31:0]   ln_pl_reg;
    logic [RW-1:0]    ln1_r_reg;
    logic             ln1_z_reg;
    logic             ln1_vld_reg;
    logic [LW+32:0]   ln_sum;
    logic [LW-1:0]    ln_reg;
    logic [RW-1:0]    ln2_r_reg;
    logic             ln2_z_reg;
    logic             ln2_vld_reg;

    assign log2v  = {lg_e_reg[2*F], lg_frac_reg[2*F]};
    assign ln_sum = (LW + 33)'(ln_ph_reg) + (LW + 33)'(ln_pl_reg >> 32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ln1_vld_reg <= 1'b0;
            ln2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            ln1_vld_reg <= lg_vld_reg[2*F];
            ln2_vld_reg <= ln1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ln_ph_reg <= (LW + 32)'(log2v) * (LW + 32)'(LN2_HI);
            ln_pl_reg <= (LW + 32)'(log2v) * (LW + 32)'(LN2_LO);
            ln1_r_reg <= lg_r_reg[2*F];
            ln1_z_reg <= lg_z_reg[2*F];
            ln_reg    <= ln_sum[LW+31:32];
            ln2_r_reg <= ln1_r_reg;
            ln2_z_reg <= ln1_z_reg;
        end
    end

    // ---------------- q = r / (r + a) ----------------
    localparam int SWQ = LW + RW + 1;
    logic          qd_vld;
    logic [F:0]    qd_quo;
    logic          qd_ovf;
    logic [SWQ-1:0] qd_side;
    logic [LW-1:0] qd_ln;
    logic [RW-1:0] qd_r;
    logic          qd_z;

    nfwpf_div #(
        .NW (RW + F),
        .DW (AW),
        .QW (F + 1),
        .SW (SWQ)
    ) u_div_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (ln2_vld_reg),
        .num      ({ln2_r_reg, {F{1'b0}}}),
        .den      (AW'(ln2_r_reg) + AW'(scale_radius_reg)),
        .side     ({ln_reg, ln2_r_reg, ln2_z_reg}),
        .out_valid(qd_vld),
        .quo      (qd_quo),
        .ovf      (qd_ovf),
        .side_out (qd_side)
    );

    assign {qd_ln, qd_r, qd_z} = qd_side;

    // ---------------- T = L - q, products with F ----------------
    logic [LW-1:0]   t_next;
    logic [LW-1:0]   t_reg;
    logic [LW-1:0]   t_ln_reg;
    logic [RW-1:0]   t_r_reg;
    logic            t_z_reg;
    logic            t_acc_reg;
    logic            t_vld_reg;
    logic [W+LW-1:0] pp_p_reg;
    logic [W+LW-1:0] pp_t_reg;
    logic [RW-1:0]   pp_r_reg;
    logic            pp_z_reg;
    logic            pp_acc_reg;
    logic            pp_vld_reg;

    assign t_next = (qd_ln > LW'(qd_quo)) ? (qd_ln - LW'(qd_quo)) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_vld_reg  <= 1'b0;
            pp_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            t_vld_reg  <= qd_vld;
            pp_vld_reg <= t_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg      <= t_next;
            t_ln_reg   <= qd_ln;
            t_r_reg    <= qd_r;
            t_z_reg    <= qd_z;
            t_acc_reg  <= qd_ovf;
            pp_p_reg   <= (W + LW)'(amplitude_reg) * (W + LW)'(t_ln_reg);
            pp_t_reg   <= (W + LW)'(amplitude_reg) * (W + LW)'(t_reg);
            pp_r_reg   <= t_r_reg;
            pp_z_reg   <= t_z_reg;
            pp_acc_reg <= t_acc_reg;
        end
    end

    // ---------------- |P| = F*L / r ----------------
    localparam int SWP = W + LW + RW + 2;
    logic            pd_vld;
    logic [W-1:0]    pd_quo;
    logic            pd_ovf;
    logic [SWP-1:0]  pd_side;
    logic [W+LW-1:0] pd_t;
    logic [RW-1:0]   pd_r;
    logic            pd_acc;
    logic            pd_z;
    logic            pd_clip;

    nfwpf_div #(
        .NW (W + LW),
        .DW (RW),
        .QW (W),
        .SW (SWP)
    ) u_div_p (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (pp_vld_reg),
        .num      (pp_p_reg),
        .den      (pp_r_reg),
        .side     ({pp_t_reg, pp_r_reg, pp_acc_reg, pp_z_reg}),
        .out_valid(pd_vld),
        .quo      (pd_quo),
        .ovf      (pd_ovf),
        .side_out (pd_side)
    );

    assign {pd_t, pd_r, pd_acc, pd_z} = pd_side;
    assign pd_clip = pd_ovf || (pd_quo > CAP);

    // ---------------- force: three successive divisions by r ----------------
    localparam int SWU = W + RW + 3;
    logic             u1_vld;
    logic [QU1-1:0]   u1_quo;
    logic             u1_ovf;
    logic [SWU-1:0]   u1_side;
    logic [W-1:0]     u1_mag;
    logic             u1_clip;
    logic             u1_acc;
    logic [RW-1:0]    u1_r;
    logic             u1_z;

    nfwpf_div #(
        .NW (W + LW),
        .DW (RW),
        .QW (QU1),
        .SW (SWU)
    ) u_div_u1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (pd_vld),
        .num      (pd_t),
        .den      (pd_r),
        .side     ({pd_quo, pd_clip, pd_acc, pd_r, pd_z}),
        .out_valid(u1_vld),
        .quo      (u1_quo),
        .ovf      (u1_ovf),
        .side_out (u1_side)
    );

    assign {u1_mag, u1_clip, u1_acc, u1_r, u1_z} = u1_side;

    logic             u2_vld;
    logic [QU2-1:0]   u2_quo;
    logic             u2_ovf;
    logic [SWU-1:0]   u2_side;
    logic [W-1:0]     u2_mag;
    logic             u2_clip;
    logic             u2_acc;
    logic [RW-1:0]    u2_r;
    logic             u2_z;

    nfwpf_div #(
        .NW (QU1 + F),
        .DW (RW),
        .QW (QU2),
        .SW (SWU)
    ) u_div_u2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (u1_vld),
        .num      ({u1_quo, {F{1'b0}}}),
        .den      (u1_r),
        .side     ({u1_mag, u1_clip, u1_acc || u1_ovf, u1_r, u1_z}),
        .out_valid(u2_vld),
        .quo      (u2_quo),
        .ovf      (u2_ovf),
        .side_out (u2_side)
    );

    assign {u2_mag, u2_clip, u2_acc, u2_r, u2_z} = u2_side;

    localparam int SWF = W + 3;
    logic           u3_vld;
    logic [W-1:0]   u3_quo;
    logic           u3_ovf;
    logic [SWF-1:0] u3_side;
    logic [W-1:0]   u3_mag;
    logic           u3_clip;
    logic           u3_acc;
    logic           u3_z;

    nfwpf_div #(
        .NW (QU2 + F),
        .DW (RW),
        .QW (W),
        .SW (SWF)
    ) u_div_u3 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (u2_vld),
        .num      ({u2_quo, {F{1'b0}}}),
        .den      (u2_r),
        .side     ({u2_mag, u2_clip, u2_acc || u2_ovf, u2_z}),
        .out_valid(u3_vld),
        .quo      (u3_quo),
        .ovf      (u3_ovf),
        .side_out (u3_side)
    );

    assign {u3_mag, u3_clip, u3_acc, u3_z} = u3_side;

    // ---------------- output register ----------------
    logic         clip_p;
    logic         clip_f;
    logic [W-1:0] mag_p;
    logic [W-1:0] mag_f;
    logic [W-1:0] potential_reg;
    logic [W-1:0] force_reg;
    logic         saturated_reg;

    // zero radius forces both magnitudes to the cap
    assign clip_p = u3_z || u3_clip;
    assign clip_f = u3_z || u3_acc || u3_ovf || (u3_quo > CAP);
    assign mag_p  = clip_p ? CAP : u3_mag;
    assign mag_f  = clip_f ? CAP : u3_quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= u3_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            potential_reg <= '0 - mag_p;
            force_reg     <= '0 - mag_f;
            saturated_reg <= clip_p || clip_f;
        end
    end

    assign result_valid        = result_valid_reg;
    assign potential           = potential_reg;
    assign radial_force_factor = force_reg;
    assign saturated           = saturated_reg;

endmodule

@@ rtl/nfwpf_checker.sv @@
// ----------------------------------------------------------------------------
// nfwpf_checker
// Port-level checks for nfw_potential_force, attached by bind.
// ----------------------------------------------------------------------------
`include "nfw_potential_force_assert.svh"

module nfwpf_checker
    import nfwpf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  radius_ready,
    input logic                  result_valid,
    input logic                  result_ready,
    input logic [DATA_WIDTH-1:0] potential,
    input logic [DATA_WIDTH-1:0] radial_force_factor
);

    `NFWPF_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(potential) && $stable(radial_force_factor), "result changed while stalled")

    `NFWPF_ASSERT_NOW(a_stall_blocks_input, result_valid && !result_ready, !radius_ready, "input taken while output full")

    `NFWPF_ASSERT_NOW(a_ready_only_on_stall, !radius_ready, result_valid && !result_ready, "input stalled without output backpressure")

    `NFWPF_ASSERT_NOW(a_nonpositive, result_valid, (potential[DATA_WIDTH-1] || potential == '0) && (radial_force_factor[DATA_WIDTH-1] || radial_force_factor == '0), "positive output")

endmodule

bind nfw_potential_force nfwpf_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_nfwpf_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .radius_ready       (radius_ready),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .potential          (potential),
    .radial_force_factor(radial_force_factor)
);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for nfw_potential_force: drives squared radii through
// the valid/ready channel, predicts potential, force factor and clip flag
// with an exact wide-integer model of the fixed-point pipeline, and compares
// every result in order under random gaps, stalls and register settings.
// ----------------------------------------------------------------------------
module tb;
    import nfwpf_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES = 1000;

    typedef struct packed {
        logic [DW-1:0] pot;
        logic [DW-1:0] force_factor;
        logic          clip;
    } halo_result_t;

    logic          clk;
    logic          rst_n;
    logic          radius_valid;
    logic          radius_ready;
    logic [DW-1:0] radius_squared;
    logic          result_valid;
    logic          result_ready;
    logic signed [DW-1:0] potential;
    logic signed [DW-1:0] radial_force_factor;
    logic          saturated;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DW-1:0] cfg_data;

    // shadow copies of the halo registers
    logic [DW-1:0] halo_a;
    logic [DW-1:0] halo_inv_a;
    logic [DW-1:0] halo_amp;

    halo_result_t pending_results[$];
    int mismatches;
    int results_seen;
    int clipped_seen;
    int idle_cycles;
    int rx_hold;
    bit rx_steady;

    nfw_potential_force dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .radius_valid        (radius_valid),
        .radius_ready        (radius_ready),
        .radius_squared      (radius_squared),
        .result_valid        (result_valid),
        .result_ready        (result_ready),
        .potential           (potential),
        .radial_force_factor (radial_force_factor),
        .saturated           (saturated),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [DW-1:0] clip_negate(input logic [127:0] mag, input bit big,
                                                   inout bit flag);
        logic [127:0] cap;
        logic [127:0] m;
        cap = 128'd1 << (DW - 1);
        if (big || mag > cap)
        begin
            flag = 1'b1;
            m = cap;
        end
        else
            m = mag;
        return DW'(128'd0 - m);
    endfunction

    function automatic halo_result_t nfw_predict(input logic [DW-1:0] rq);
        halo_result_t res;
        logic [63:0]  r;
        logic [63:0]  t;
        logic [63:0]  y;
        logic [63:0]  mant;
        logic [63:0]  frac;
        logic [63:0]  log2v;
        logic [63:0]  ln_y;
        logic [63:0]  q;
        logic [127:0] sq;
        logic [127:0] u;
        int m;
        bit flag;
        bit big;
        flag = 1'b0;
        big = 1'b0;
        if (rq == 0)
        begin
            res.pot = {1'b1, {(DW-1){1'b0}}};
            res.force_factor = res.pot;
            res.clip = 1'b1;
            return res;
        end
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (128'(t) * 128'(t) <= (128'(rq) << FB))
                r = t;
        end
        y = ((r * 64'(halo_inv_a)) >> FB) + (64'd1 << FB);
        m = 63;
        while (m > 0 && !y[m])
            m--;
        mant = (m >= 62) ? (y >> (m - 62)) : (y << (62 - m));
        frac = 0;
        for (int i = 0; i < FB; i++)
        begin
            sq = (128'(mant) * 128'(mant)) >> 62;
            mant = sq[63:0];
            frac = frac << 1;
            if (mant[63])
            begin
                frac[0] = 1'b1;
                mant = mant >> 1;
            end
        end
        log2v = (64'(m - FB) << FB) | frac;
        sq = (128'(log2v) * 128'(LN2_Q64)) >> 64;
        ln_y = sq[63:0];
        res.pot = clip_negate((128'(halo_amp) * 128'(ln_y)) / 128'(r), 1'b0, flag);
        sq = (128'(r) << FB) / (128'(r) + 128'(halo_a));
        q = sq[63:0];
        u = (128'(halo_amp) * 128'(ln_y > q ? ln_y - q : 64'd0)) / 128'(r);
        for (int k = 0; k < 2 && !big; k++)
        begin
            if (u >= (128'd1 << (127 - FB)))
                big = 1'b1;
            else
                u = (u << FB) / 128'(r);
        end
        res.force_factor = clip_negate(u, big, flag);
        res.clip = flag;
        return res;
    endfunction

    // input and config transfers: predict and track registers
    always @(posedge clk)
    begin
        if (rst_n && radius_valid && radius_ready)
            pending_results.push_back(nfw_predict(radius_squared));
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCALE_RADIUS:     halo_a <= cfg_data;
                REG_INV_SCALE_RADIUS: halo_inv_a <= cfg_data;
                REG_AMPLITUDE:        halo_amp <= cfg_data;
                default: ;
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        halo_result_t exp_res;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (saturated)
                clipped_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result pot=%h ff=%h sat=%b",
                             potential, radial_force_factor, saturated);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (potential !== exp_res.pot || radial_force_factor !== exp_res.force_factor
                    || saturated !== exp_res.clip)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d pot exp %h got %h, ff exp %h got %h, sat exp %b got %b",
                                 results_seen, exp_res.pot, potential,
                                 exp_res.force_factor, radial_force_factor,
                                 exp_res.clip, saturated);
                end
            end
        end
    end

    // watchdog: cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if ((radius_valid && radius_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: watchdog expired, %0d results outstanding",
                     pending_results.size());
            $display("FAIL nfw_potential_force");
            $finish;
        end
    end

    // result receiver with random stalls; rx_hold forces a long hold-off
    always @(negedge clk)
    begin
        int stall;
        int pick;
        if (rx_hold > 0)
        begin
            result_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else if (rx_steady || stall == 0)
        begin
            result_ready <= 1'b1;
            pick = $urandom_range(0, 99);
            if (!rx_steady && pick < 25)
                stall = (pick < 2) ? $urandom_range(20, 80) : $urandom_range(1, 3);
        end
        else
        begin
            result_ready <= 1'b0;
            stall--;
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 97)
            return $urandom_range(1, 3);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [DW-1:0] rand_radius();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(0, 31);
            2: return $urandom_range(0, 16);
            default: return $urandom >> $urandom_range(8, 24);
        endcase
    endfunction

    task automatic send_radius(input logic [DW-1:0] rq, input int gap);
        @(negedge clk);
        radius_valid <= 1'b1;
        radius_squared <= rq;
        forever
        begin
            @(posedge clk);
            if (radius_ready)
                break;
        end
        if (gap > 0)
        begin
            @(negedge clk);
            radius_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DW-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        radius_valid <= 1'b0;
        wait (pending_results.size() == 0);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_radius(rand_radius(), pick_gap());
    endtask

    task automatic test_directed();
        logic [DW-1:0] corners[$] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'h0000_ffff,
            32'h0001_0000, 32'h0001_0001, 32'h0004_0000, 32'h0010_0000, 32'h7fff_ffff,
            32'h8000_0000, 32'hffff_fffe, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa};
        foreach (corners[i])
            send_radius(corners[i], i % 2);
        drain();
    endtask

    task automatic test_register_sweep();
        logic [DW-1:0] a_vals[$]   = '{32'd1, 32'hffff_ffff, 32'h0000_8000, 32'h0020_0000};
        logic [DW-1:0] inv_vals[$] = '{32'hffff_ffff, 32'd1, 32'h0002_0000, 32'h0000_0800};
        logic [DW-1:0] amp_vals[$] = '{32'hffff_ffff, 32'd0, 32'h0100_0000, 32'h0000_1234};
        foreach (a_vals[i])
        begin
            write_reg(REG_SCALE_RADIUS, a_vals[i]);
            write_reg(REG_INV_SCALE_RADIUS, inv_vals[i]);
            write_reg(REG_AMPLITUDE, amp_vals[i]);
            send_radius(32'd0, 0);
            send_radius(32'd1, 0);
            send_radius(32'hffff_ffff, 0);
            run_random(80);
            drain();
        end
        // unmapped index must leave the registers alone
        write_reg(REG_UNMAPPED, 32'h1234_5678);
        write_reg(REG_SCALE_RADIUS, $urandom_range(1, 32'h0040_0000));
        write_reg(REG_INV_SCALE_RADIUS, $urandom_range(1, 32'h0040_0000));
        write_reg(REG_AMPLITUDE, $urandom);
        run_random(60);
        drain();
        write_reg(REG_SCALE_RADIUS, 32'h0001_0000);
        write_reg(REG_INV_SCALE_RADIUS, 32'h0001_0000);
        write_reg(REG_AMPLITUDE, 32'h0004_a000);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++)
        begin
            rx_steady = (phase == 2);
            for (int i = 0; i < 150; i++)
                send_radius(rand_radius(), (phase == 2) ? 0 : pick_gap());
            drain();
            write_reg(REG_SCALE_RADIUS, $urandom);
            write_reg(REG_INV_SCALE_RADIUS, $urandom >> $urandom_range(0, 24));
            write_reg(REG_AMPLITUDE, $urandom >> $urandom_range(0, 16));
        end
        rx_steady = 1'b0;
    endtask

    // more items than the pipeline holds, so the input stalls during the hold
    task automatic test_backpressure();
        rx_hold = 600;
        for (int i = 0; i < 300; i++)
            send_radius(rand_radius(), 0);
        drain();
    endtask

    task automatic test_sender_pause();
        for (int round = 0; round < 3; round++)
        begin
            for (int i = 0; i < 20; i++)
                send_radius(rand_radius(), pick_gap());
            drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        radius_valid = 1'b0;
        radius_squared = '0;
        result_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SCALE_RADIUS;
        cfg_data = '0;
        halo_a = 32'h0001_0000;
        halo_inv_a = 32'h0001_0000;
        halo_amp = 32'h0004_a000;
        mismatches = 0;
        results_seen = 0;
        clipped_seen = 0;
        rx_hold = 0;
        rx_steady = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_register_sweep();
        test_random_traffic();
        test_backpressure();
        test_sender_pause();

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d results (%0d clipped) over corner radii, register extremes,",
                 results_seen, clipped_seen);
        $display("random traffic, a long output hold-off and drained sender pauses.");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS nfw_potential_force");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
            $display("FAIL nfw_potential_force");
        end
        $finish;
    end
endmodule
